@@ rtl/core/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Shared widths, command and status codes for the bounded lifo stack.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  localparam int unsigned DEPTH_DEF = 8;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [WORD_W-1:0] WORD_ZERO = '0;
  localparam logic [WORD_W-1:0] WORD_ONES = '1;

  // memory port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/bounded_lifo_stack_top.sv @@
// ----------------------------------------------------------------------------
// bounded_lifo_stack_top
// Fixed-depth lifo stack of signed words with push, pop and display commands.
// ----------------------------------------------------------------------------
// The stack words live in a synchronous memory with a registered read; only the
// fill count and control state are cleared by reset, so no clearing pass is
// needed. A push writes and answers straight from idle. A pop runs request,
// memory read and result load. A display repeats memory read and result load
// per stored word, each paying the memory read latency; an empty pop or display
// and a full push answer straight from idle. Command code 3 is dropped with no
// result. The result sits in an output register, so a new request is taken in
// the same cycle the previous result is handed over.
`default_nettype none

module bounded_lifo_stack_top #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // request channel
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire  [bls_pkg::WORD_W-1:0]       s_axis_tdata_i,   // push_value[31:0]
  input  wire  [bls_pkg::CMD_W-1:0]        s_axis_tuser_i,   // cmd[1:0]
  // result channel
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  output logic [bls_pkg::WORD_W-1:0]       m_axis_tdata_o,   // data_word[31:0]
  output logic [bls_pkg::STATUS_W-1:0]     m_axis_tuser_o,   // status[1:0]
  output logic                             m_axis_tlast_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          disp_q, disp_d;

  logic                         out_valid_q, out_valid_d;
  logic [bls_pkg::WORD_W-1:0]   out_data_q, out_data_d;
  logic [bls_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                         out_last_q, out_last_d;

  bls_pkg::ram_ctrl_t         ram_ctrl;
  logic [AW-1:0]              rd_addr;
  logic [bls_pkg::WORD_W-1:0] rd_data;

  logic          out_free;
  logic          req_acc;
  logic          is_full;
  logic          is_empty;
  logic [CW-1:0] count_dec;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign req_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full   = (count_q == CW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign count_dec = count_q - CW'(1);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    disp_d       = disp_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    ram_ctrl     = '0;
    rd_addr      = idx_q;

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          case (s_axis_tuser_i)
            bls_pkg::CMD_PUSH: begin
              out_valid_d = 1'b1;
              out_data_d  = bls_pkg::WORD_ZERO;
              out_last_d  = 1'b1;
              if (is_full) begin
                out_status_d = bls_pkg::ST_FULL;
              end else begin
                out_status_d   = bls_pkg::ST_OK;
                ram_ctrl.wr_en = 1'b1;
                count_d        = count_q + CW'(1);
              end
            end
            bls_pkg::CMD_POP, bls_pkg::CMD_DISPLAY: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_status_d = bls_pkg::ST_EMPTY;
                out_last_d   = 1'b1;
                out_data_d   = (s_axis_tuser_i == bls_pkg::CMD_POP) ?
                               bls_pkg::WORD_ONES : bls_pkg::WORD_ZERO;
              end else begin
                ram_ctrl.rd_en = 1'b1;
                rd_addr        = count_dec[AW-1:0];
                idx_d          = count_dec[AW-1:0];
                disp_d         = (s_axis_tuser_i == bls_pkg::CMD_DISPLAY);
                state_d        = S_WAIT;
                if (s_axis_tuser_i == bls_pkg::CMD_POP) begin
                  count_d = count_dec;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_WAIT: begin
        state_d = S_DATA;
      end
      S_DATA: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = rd_data;
          out_status_d = bls_pkg::ST_OK;
          out_last_d   = !disp_q || (idx_q == '0);
          if (!disp_q || (idx_q == '0)) begin
            state_d = S_IDLE;
          end else begin
            // walk down toward the bottom word
            idx_d          = idx_q - AW'(1);
            rd_addr        = idx_q - AW'(1);
            ram_ctrl.rd_en = 1'b1;
            state_d        = S_WAIT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      disp_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      disp_q      <= disp_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  bls_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .ctrl_i    (ram_ctrl),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (s_axis_tdata_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/bls_ram.sv @@
// ----------------------------------------------------------------------------
// bls_ram
// Simple dual-port word memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_ram #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                           clk_i,
  input  wire  bls_pkg::ram_ctrl_t      ctrl_i,
  input  wire  [AW-1:0]                 wr_addr_i,
  input  wire  [bls_pkg::WORD_W-1:0]    wr_data_i,
  input  wire  [AW-1:0]                 rd_addr_i,
  output logic [bls_pkg::WORD_W-1:0]    rd_data_o
);

  logic [bls_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read strobe
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire
